FILE: rtl/sfd_pkg.sv
// Shared types and constants for the serial frame deframer/checker.
`default_nettype none
package sfd_pkg;

	localparam logic [7:0] HDR_BYTE   = 8'hFF;
	localparam logic [7:0] STUFF_BYTE = 8'h55;
	localparam logic [15:0] MIN_LEN   = 16'd5;
	// body bytes before the first payload byte: cmd, seq, two flags
	localparam logic [15:0] BODY_HDR_LEN = 16'd4;

	localparam logic KIND_PAYLOAD = 1'b0;
	localparam logic KIND_END     = 1'b1;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_SEQ_ERR  = 2'd1;
	localparam logic [1:0] ST_SUM_ERR  = 2'd2;
	localparam logic [1:0] ST_LEN_ERR  = 2'd3;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	typedef enum logic [4:0] {
		PH_HUNT0  = 5'b00001,
		PH_HUNT1  = 5'b00010,
		PH_LEN_HI = 5'b00100,
		PH_LEN_LO = 5'b01000,
		PH_BODY   = 5'b10000
	} phase_t;

	typedef struct packed {
		logic       kind;
		logic [7:0] payload;
		logic [7:0] cmd;
		logic [1:0] status;
	} rec_t;

endpackage
`default_nettype wire

FILE: rtl/sfd_front.sv
// Front end: header hunt, unstuffing, length/body tracking and record generation.
`default_nettype none
module sfd_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          accept,
	input  wire logic [7:0]    rx_byte,
	input  wire logic [7:0]    expected_seq,
	output logic               rec_valid,
	output sfd_pkg::rec_t      rec
);

	sfd_pkg::phase_t phase_q, phase_d;
	logic        skip_q, skip_d;
	logic [15:0] len_q, len_d;
	logic [15:0] cnt_q, cnt_d;
	logic [7:0]  sum_q, sum_d;
	logic [7:0]  cmd_q, cmd_d;
	logic        seqm_q, seqm_d;

	logic        is_hdr;
	logic        drop;
	logic [7:0]  sum_add;
	logic [15:0] len_full;
	logic [16:0] cnt_inc;
	logic        last_byte;

	assign is_hdr    = (rx_byte == sfd_pkg::HDR_BYTE);
	assign drop      = skip_q && (rx_byte == sfd_pkg::STUFF_BYTE);
	assign sum_add   = sum_q + rx_byte;
	assign len_full  = {len_q[15:8], rx_byte};
	assign cnt_inc   = {1'b0, cnt_q} + 17'd1;
	assign last_byte = (cnt_inc >= {1'b0, len_q});

	always_comb begin
		phase_d   = phase_q;
		skip_d    = skip_q;
		len_d     = len_q;
		cnt_d     = cnt_q;
		sum_d     = sum_q;
		cmd_d     = cmd_q;
		seqm_d    = seqm_q;
		rec_valid = 1'b0;
		rec       = '0;
		case (phase_q)
			sfd_pkg::PH_HUNT1: begin
				if (is_hdr) begin
					phase_d = sfd_pkg::PH_LEN_HI;
					skip_d  = 1'b0;
					len_d   = '0;
					cnt_d   = '0;
					sum_d   = '0;
					cmd_d   = '0;
					seqm_d  = 1'b0;
				end else begin
					phase_d = sfd_pkg::PH_HUNT0;
				end
			end
			sfd_pkg::PH_LEN_HI, sfd_pkg::PH_LEN_LO, sfd_pkg::PH_BODY: begin
				if (drop) begin
					skip_d = 1'b0;
				end else begin
					skip_d = is_hdr;
					case (phase_q)
						sfd_pkg::PH_LEN_HI: begin
							len_d   = {rx_byte, 8'h00};
							sum_d   = sum_add;
							phase_d = sfd_pkg::PH_LEN_LO;
						end
						sfd_pkg::PH_LEN_LO: begin
							len_d = len_full;
							sum_d = sum_add;
							cnt_d = '0;
							if (len_full < sfd_pkg::MIN_LEN) begin
								phase_d       = sfd_pkg::PH_HUNT0;
								skip_d        = 1'b0;
								rec_valid     = 1'b1;
								rec.kind      = sfd_pkg::KIND_END;
								rec.status    = sfd_pkg::ST_LEN_ERR;
							end else begin
								phase_d = sfd_pkg::PH_BODY;
							end
						end
						default: begin
							if (last_byte) begin
								// checksum byte: seq fault wins over sum fault
								phase_d   = sfd_pkg::PH_HUNT0;
								skip_d    = 1'b0;
								rec_valid = 1'b1;
								rec.kind  = sfd_pkg::KIND_END;
								rec.cmd   = cmd_q;
								if (!seqm_q)
									rec.status = sfd_pkg::ST_SEQ_ERR;
								else if (rx_byte != sum_q)
									rec.status = sfd_pkg::ST_SUM_ERR;
								else
									rec.status = sfd_pkg::ST_OK;
							end else begin
								sum_d = sum_add;
								if (cnt_q == 16'd0)
									cmd_d = rx_byte;
								else if (cnt_q == 16'd1)
									seqm_d = (rx_byte == expected_seq);
								cnt_d = cnt_inc[15:0];
								if (cnt_q >= sfd_pkg::BODY_HDR_LEN) begin
									rec_valid   = 1'b1;
									rec.kind    = sfd_pkg::KIND_PAYLOAD;
									rec.payload = rx_byte;
								end
							end
						end
					endcase
				end
			end
			default: begin
				phase_d = is_hdr ? sfd_pkg::PH_HUNT1 : sfd_pkg::PH_HUNT0;
			end
		endcase
		if (!accept)
			rec_valid = 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= sfd_pkg::PH_HUNT0;
			skip_q  <= 1'b0;
			len_q   <= '0;
			cnt_q   <= '0;
			sum_q   <= '0;
			cmd_q   <= '0;
			seqm_q  <= 1'b0;
		end else if (accept) begin
			phase_q <= phase_d;
			skip_q  <= skip_d;
			len_q   <= len_d;
			cnt_q   <= cnt_d;
			sum_q   <= sum_d;
			cmd_q   <= cmd_d;
			seqm_q  <= seqm_d;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/sfd_fifo.sv
// Short record queue between the front end and the result ports.
`default_nettype none
module sfd_fifo (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          wr_en,
	input  wire sfd_pkg::rec_t wr_rec,
	input  wire logic          rd_en,
	output logic               full,
	output logic               empty,
	output sfd_pkg::rec_t      rd_rec
);

	sfd_pkg::rec_t mem_q [sfd_pkg::QDEPTH];
	logic [sfd_pkg::QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [sfd_pkg::QCNT_W-1:0] count_q;
	logic do_wr, do_rd;

	assign full   = (count_q == sfd_pkg::QCNT_W'(sfd_pkg::QDEPTH));
	assign empty  = (count_q == '0);
	assign do_wr  = wr_en && !full;
	assign do_rd  = rd_en && !empty;
	assign rd_rec = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr)
			mem_q[wr_ptr_q] <= wr_rec;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_rd)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_wr && !do_rd)
				count_q <= count_q + 1'b1;
			else if (do_rd && !do_wr)
				count_q <= count_q - 1'b1;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/serial_frame_deframer_checker.sv
// Serial frame deframer/checker top level.
// Throughput: one byte per cycle; a byte is taken whenever the 4-entry record queue has room.
// A record is written into the queue with the byte that produces it and is visible (empty low) in the cycle after it.
// Backpressure: full rises only once four records wait unpopped.
// Reset: arst_n clears the hunt state and empties the queue; no clearing pass.
`default_nettype none
module serial_frame_deframer_checker (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push,
	output logic            full,
	input  wire logic [7:0] rx_byte,
	input  wire logic [7:0] expected_seq,
	output logic            empty,
	input  wire logic       pop,
	output logic            record_kind,
	output logic [7:0]      payload_byte,
	output logic [7:0]      frame_cmd,
	output logic [1:0]      frame_status
);

	logic          accept;
	logic          rec_valid;
	sfd_pkg::rec_t rec;
	sfd_pkg::rec_t head;

	assign accept = push && !full;

	sfd_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.rx_byte      (rx_byte),
		.expected_seq (expected_seq),
		.rec_valid    (rec_valid),
		.rec          (rec)
	);

	sfd_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (rec_valid),
		.wr_rec (rec),
		.rd_en  (pop),
		.full   (full),
		.empty  (empty),
		.rd_rec (head)
	);

	assign record_kind  = head.kind;
	assign payload_byte = head.payload;
	assign frame_cmd    = head.cmd;
	assign frame_status = head.status;

endmodule
`default_nettype wire

FILE: rtl/sfd_checker.sv
// Port-level assertions for the deframer/checker, bound to the top level.
`default_nettype none
module sfd_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       push,
	input wire logic       full,
	input wire logic       empty,
	input wire logic       pop,
	input wire logic       record_kind,
	input wire logic [7:0] payload_byte,
	input wire logic [7:0] frame_cmd,
	input wire logic [1:0] frame_status
);

	// too-short frames never captured a cmd byte
	a_len_err_no_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && record_kind == sfd_pkg::KIND_END && frame_status == sfd_pkg::ST_LEN_ERR)
		|-> frame_cmd == 8'h00)
		else $error("length error record carries a cmd byte");

	a_payload_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && record_kind == sfd_pkg::KIND_PAYLOAD)
		|-> (frame_cmd == 8'h00 && frame_status == sfd_pkg::ST_OK))
		else $error("payload item with cmd or status set");

	a_end_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && record_kind == sfd_pkg::KIND_END) |-> payload_byte == 8'h00)
		else $error("end item with payload byte set");

	// records only appear from accepted bytes
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		(empty && !push) |=> empty)
		else $error("item appeared without a push");

	a_full_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(full && !pop) |=> full)
		else $error("full dropped without a pop");

endmodule

bind serial_frame_deframer_checker sfd_checker u_sfd_checker (.*);
`default_nettype wire
